### rtl/set_assoc_cache_lru_sim_top_defines.svh
// Assertion macros shared by the checker.
`ifndef SET_ASSOC_CACHE_LRU_SIM_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_SIM_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SACL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define SACL_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/sacl_pkg.sv
package sacl_pkg;

  localparam int MaxSetBits = 10;
  localparam int MaxWays    = 8;
  localparam int AddrWidth  = 48;
  localparam int FifoDepth  = 2;

  typedef enum logic [1:0] {
    FUNC_INSTR  = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_STORE  = 2'd2,
    FUNC_MODIFY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OUT_IGNORED = 2'd0,
    OUT_HIT     = 2'd1,
    OUT_FILL    = 2'd2,
    OUT_EVICT   = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_OUT
  } back_state_t;

endpackage

### rtl/sacl_front.sv
// Classifies a request into set index, tag, active and modify flags, then queues it.
module sacl_front #(
  parameter int MAX_SET_BITS = sacl_pkg::MaxSetBits,
  parameter int ADDR_WIDTH   = sacl_pkg::AddrWidth,
  parameter int DEPTH        = sacl_pkg::FifoDepth
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      func,
  input  logic [ADDR_WIDTH-1:0]           address,
  input  logic [3:0]                      set_bits,
  input  logic [4:0]                      block_bits,
  output logic                            q_valid,
  input  logic                            q_ready,
  output logic                            q_active,
  output logic                            q_modify,
  output logic [(MAX_SET_BITS>0?MAX_SET_BITS:1)-1:0] q_set,
  output logic [ADDR_WIDTH-1:0]           q_tag
);
  import sacl_pkg::*;
  localparam int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = 2 + SW + ADDR_WIDTH;

  logic [EW-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic [3:0]    sb;
  logic [5:0]    tshift;
  logic [ADDR_WIDTH-1:0] shifted, set_mask;
  logic [EW-1:0] entry;
  logic push, pop;

  always_comb begin
    sb = (32'(set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : set_bits;
    tshift = 6'(sb) + 6'(block_bits);
    shifted = address >> block_bits;
    set_mask = ~({ADDR_WIDTH{1'b1}} << sb);
    entry = {func != FUNC_INSTR, func == FUNC_MODIFY,
             SW'(shifted & set_mask), address >> tshift};
  end

  assign in_ready = (count != (PW+1)'(DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (count != '0);
  assign pop = q_valid && q_ready;
  assign {q_active, q_modify, q_set, q_tag} = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (32'(wr_ptr) == DEPTH-1) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (32'(rd_ptr) == DEPTH-1) ? '0 : rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

### rtl/sacl_back.sv
// Reads a set, compares tags, picks hit/fill/victim, writes the set back.
module sacl_back #(
  parameter int MAX_SET_BITS = sacl_pkg::MaxSetBits,
  parameter int MAX_WAYS     = sacl_pkg::MaxWays,
  parameter int ADDR_WIDTH   = sacl_pkg::AddrWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic                  q_active,
  input  logic                  q_modify,
  input  logic [(MAX_SET_BITS>0?MAX_SET_BITS:1)-1:0] q_set,
  input  logic [ADDR_WIDTH-1:0] q_tag,
  input  logic [3:0]            ways_in_use,
  input  logic                  busy_clear,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            outcome,
  output logic [2:0]            way_used,
  output logic [31:0]           hit_total,
  output logic [31:0]           miss_total,
  output logic [31:0]           eviction_total
);
  import sacl_pkg::*;
  localparam int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NS = 1 << MAX_SET_BITS;
  localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam logic [AW-1:0] AGE_MAX = AW'(MAX_WAYS - 1);
  localparam int LW = 1 + ADDR_WIDTH + AW;
  localparam int RW = MAX_WAYS * LW;

  back_state_t state, state_next;

  // set memory, one row per set: {valid, tag, age} per way
  logic [RW-1:0] mem [NS];
  logic [RW-1:0] row_rd;
  logic [RW-1:0] row_wr;
  logic [SW-1:0] wr_addr;
  logic          wr_en;
  logic [SW-1:0] clr_ptr;
  logic          clearing;

  logic          r_modify, r_active;
  logic [SW-1:0] r_set;
  logic [ADDR_WIDTH-1:0] r_tag;
  logic [3:0]    ways;

  logic [MAX_WAYS-1:0]  v;
  logic [ADDR_WIDTH-1:0] t [MAX_WAYS];
  logic [AW-1:0]        a [MAX_WAYS];
  logic                 hit, has_free;
  logic [WW-1:0]        hit_w, free_w, vic_w, sel_w;
  logic [AW-1:0]        bound;
  logic [1:0]           oc;

  always_comb begin
    ways = (ways_in_use == 4'd0) ? 4'd1 :
           (32'(ways_in_use) > MAX_WAYS) ? 4'(MAX_WAYS) : ways_in_use;
    for (int i = 0; i < MAX_WAYS; i++) begin
      v[i] = row_rd[i*LW + AW + ADDR_WIDTH];
      t[i] = row_rd[i*LW + AW +: ADDR_WIDTH];
      a[i] = row_rd[i*LW +: AW];
    end
  end

  // way selection (hit, first free, oldest)
  always_comb begin
    hit = 1'b0; hit_w = '0; has_free = 1'b0; free_w = '0; vic_w = '0;
    for (int i = MAX_WAYS-1; i >= 0; i--) begin
      if (i < 32'(ways)) begin
        if (v[i] && t[i] == r_tag) begin
          hit = 1'b1; hit_w = WW'(i);
        end
        if (!v[i]) begin
          has_free = 1'b1; free_w = WW'(i);
        end
      end
    end
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (i < 32'(ways) && a[i] > a[vic_w]) vic_w = WW'(i);
    end
    if (hit) begin
      oc = OUT_HIT; sel_w = hit_w; bound = a[hit_w];
    end else if (has_free) begin
      oc = OUT_FILL; sel_w = free_w; bound = AGE_MAX;
    end else begin
      oc = OUT_EVICT; sel_w = vic_w; bound = a[vic_w];
    end
    row_wr = row_rd;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < 32'(ways) && WW'(i) != sel_w && v[i] && a[i] < AGE_MAX &&
          (oc == OUT_FILL || a[i] < bound))
        row_wr[i*LW +: AW] = a[i] + 1'b1;
    end
    // fill ages every other valid line whose age is below AGE_MAX
    row_wr[32'(sel_w)*LW +: AW] = '0;
    row_wr[32'(sel_w)*LW + AW + ADDR_WIDTH] = 1'b1;
    row_wr[32'(sel_w)*LW + AW +: ADDR_WIDTH] = r_tag;
  end

  assign clearing = busy_clear;
  assign wr_en   = clearing || (state == ST_UPDATE && r_active);
  assign wr_addr = clearing ? clr_ptr : r_set;

  // row is captured when the request is popped and held through the update
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= clearing ? '0 : row_wr;
    if (state == ST_IDLE) row_rd <= mem[q_set];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_ptr <= '0;
    else if (clearing) clr_ptr <= clr_ptr + 1'b1;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (q_valid && !clearing) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_OUT;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state == ST_IDLE) && !clearing;
    out_valid = (state == ST_OUT);
  end

  function automatic logic [31:0] sat(input logic [31:0] x, input logic inc);
    sat = (inc && x != 32'hFFFF_FFFF) ? x + 32'd1 : x;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hit_total <= '0;
      miss_total <= '0;
      eviction_total <= '0;
    end else begin
      state <= state_next;
      if (state == ST_UPDATE && r_active) begin
        hit_total <= sat(sat(hit_total, oc == OUT_HIT), r_modify);
        miss_total <= sat(miss_total, oc != OUT_HIT);
        eviction_total <= sat(eviction_total, oc == OUT_EVICT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && !clearing) begin
      r_active <= q_active;
      r_modify <= q_modify;
      r_set    <= q_set;
      r_tag    <= q_tag;
    end
    if (state == ST_UPDATE) begin
      outcome  <= r_active ? oc : OUT_IGNORED;
      way_used <= r_active ? 3'(sel_w) : 3'd0;
    end
  end
endmodule

### rtl/set_assoc_cache_lru_sim_top.sv
// Flow: a request is queued, then the back end pops it, reads the set, updates it
// and hands off the result; a request waits in the queue while an earlier one is still there.
// The back end takes a new request only after the result of the last one is taken;
// the queue can hold requests meanwhile.
// Reset: counters, queue and config return to defaults; a clearing pass over
// all 2**MAX_SET_BITS rows (1024 by default) zeroes the set memory, and the back end
// pops no requests meanwhile.
module set_assoc_cache_lru_sim_top #(
  parameter int MAX_SET_BITS = sacl_pkg::MaxSetBits,
  parameter int MAX_WAYS     = sacl_pkg::MaxWays,
  parameter int ADDR_WIDTH   = sacl_pkg::AddrWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  input  logic [ADDR_WIDTH-1:0] address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            outcome,
  output logic [2:0]            way_used,
  output logic [31:0]           hit_total,
  output logic [31:0]           miss_total,
  output logic [31:0]           eviction_total,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [4:0]            cfg_data
);
  import sacl_pkg::*;
  localparam int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NS = 1 << MAX_SET_BITS;

  logic [3:0] set_bits, ways_in_use;
  logic [4:0] block_bits;
  logic q_valid, q_ready, q_active, q_modify;
  logic [SW-1:0] q_set;
  logic [ADDR_WIDTH-1:0] q_tag;
  logic [MAX_SET_BITS:0] clr_cnt;
  logic clearing;

  assign clearing = (32'(clr_cnt) != NS);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      set_bits <= 4'd4;
      block_bits <= 5'd4;
      ways_in_use <= 4'd1;
    end else begin
      if (clearing) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SET_BITS:   set_bits <= cfg_data[3:0];
          CFG_BLOCK_BITS: block_bits <= cfg_data;
          CFG_WAYS:       ways_in_use <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  sacl_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDR_WIDTH(ADDR_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .func, .address, .set_bits, .block_bits,
    .q_valid, .q_ready, .q_active, .q_modify, .q_set, .q_tag
  );

  sacl_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS),
              .ADDR_WIDTH(ADDR_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_active, .q_modify, .q_set, .q_tag,
    .ways_in_use, .busy_clear(clearing), .out_valid, .out_ready, .outcome,
    .way_used, .hit_total, .miss_total, .eviction_total
  );
endmodule

### rtl/sacl_checker.sv
`include "set_assoc_cache_lru_sim_top_defines.svh"
module sacl_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  outcome,
  input logic [2:0]  way_used,
  input logic [31:0] miss_total,
  input logic [31:0] eviction_total
);
  import sacl_pkg::*;
  `SACL_ASSERT_IMP(a_ign_way, clk, rst, out_valid && outcome == OUT_IGNORED, way_used == 3'd0)
  `SACL_ASSERT_IMP(a_evict_le_miss, clk, rst, out_valid, eviction_total <= miss_total)
  `SACL_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, $stable(outcome) && out_valid)
endmodule

bind set_assoc_cache_lru_sim_top sacl_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .outcome, .way_used, .miss_total, .eviction_total
);

### tb/sacl_result_checker.sv
module sacl_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  func,
  input  logic [47:0] address,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  outcome,
  input  logic [2:0]  way_used,
  input  logic [31:0] hit_total,
  input  logic [31:0] miss_total,
  input  logic [31:0] eviction_total,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output int          pending,
  output int          errors,
  output int          hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import sacl_pkg::*;

  localparam int NumSets = 1 << MaxSetBits;
  localparam logic [2:0] AgeMax = 3'(MaxWays - 1);

  typedef struct packed {
    outcome_t    oc;
    logic [2:0]  way;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } access_result_t;

  access_result_t expected_results[$];

  bit          line_ok  [NumSets][MaxWays];
  logic [47:0] line_tag [NumSets][MaxWays];
  logic [2:0]  line_age [NumSets][MaxWays];
  logic [31:0] hits_cnt, miss_cnt, evict_cnt;
  logic [3:0]  set_bits_r, ways_r;
  logic [4:0]  block_bits_r;
  int          err_cnt, hit_cnt;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  task automatic promote(int set, int w, int bound, int ways);
    for (int i = 0; i < ways; i++) begin
      if (i != w && line_ok[set][i] && line_age[set][i] < bound && line_age[set][i] < AgeMax)
        line_age[set][i] = line_age[set][i] + 1;
    end
    line_age[set][w] = 0;
  endtask

  task automatic lookup_line(logic [47:0] addr, output outcome_t oc, output logic [2:0] way);
    int sb, ways, set, victim;
    logic [47:0] tag;
    sb = (set_bits_r > MaxSetBits) ? MaxSetBits : set_bits_r;
    ways = (ways_r == 0) ? 1 : (ways_r > MaxWays) ? MaxWays : ways_r;
    set = int'((addr >> block_bits_r) & ((48'd1 << sb) - 1));
    tag = addr >> (sb + block_bits_r);
    for (int i = 0; i < ways; i++) begin
      if (line_ok[set][i] && line_tag[set][i] == tag) begin
        hits_cnt = sat_inc(hits_cnt);
        promote(set, i, line_age[set][i], ways);
        oc = OUT_HIT;
        way = 3'(i);
        return;
      end
    end
    miss_cnt = sat_inc(miss_cnt);
    for (int i = 0; i < ways; i++) begin
      if (!line_ok[set][i]) begin
        line_ok[set][i] = 1'b1;
        line_tag[set][i] = tag;
        promote(set, i, MaxWays, ways);
        oc = OUT_FILL;
        way = 3'(i);
        return;
      end
    end
    // oldest line goes; lowest way on a tie
    victim = 0;
    for (int i = 1; i < ways; i++)
      if (line_age[set][i] > line_age[set][victim]) victim = i;
    evict_cnt = sat_inc(evict_cnt);
    line_tag[set][victim] = tag;
    promote(set, victim, line_age[set][victim], ways);
    oc = OUT_EVICT;
    way = 3'(victim);
  endtask

  function automatic int check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    access_result_t r;
    outcome_t oc;
    logic [2:0] w;
    if (rst) begin
      foreach (line_ok[s, i]) begin
        line_ok[s][i] = 1'b0;
        line_age[s][i] = '0;
      end
      hits_cnt = '0;
      miss_cnt = '0;
      evict_cnt = '0;
      set_bits_r = 4'd4;
      block_bits_r = 5'd4;
      ways_r = 4'd1;
      expected_results.delete();
      err_cnt = 0;
      hit_cnt = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending, got outcome %0d way %0d",
                   $time, outcome, way_used);
          err_cnt++;
        end else begin
          r = expected_results.pop_front();
          err_cnt += check_field("outcome", r.oc, outcome);
          err_cnt += check_field("way_used", r.way, way_used);
          err_cnt += check_field("hit_total", r.hits, hit_total);
          err_cnt += check_field("miss_total", r.misses, miss_total);
          err_cnt += check_field("eviction_total", r.evicts, eviction_total);
          if (r.oc == OUT_HIT) hit_cnt++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_BITS:   set_bits_r = cfg_data[3:0];
          CFG_BLOCK_BITS: block_bits_r = cfg_data;
          CFG_WAYS:       ways_r = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        oc = OUT_IGNORED;
        w = '0;
        if (func_t'(func) != FUNC_INSTR) begin
          lookup_line(address, oc, w);
          if (func_t'(func) == FUNC_MODIFY) hits_cnt = sat_inc(hits_cnt);
        end
        expected_results.push_back('{oc, w, hits_cnt, miss_cnt, evict_cnt});
      end
    end
    pending <= expected_results.size();
    errors <= err_cnt;
    hits_seen <= hit_cnt;
  end
endmodule

### tb/tb_set_assoc_cache_lru_sim_top.sv
module tb_set_assoc_cache_lru_sim_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sacl_pkg::*;

  localparam int CycleLimit = 600000;
  localparam logic [1:0] CfgUnused = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [47:0] address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  outcome;
  logic [2:0]  way_used;
  logic [31:0] hit_total, miss_total, eviction_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;
  int          pending, errors, hits_seen;
  int          cycles = 0, sent = 0, cfg_writes = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;
  int          cur_sb = 4, cur_bb = 4, cur_ways = 1;

  always #10 clk = ~clk;

  set_assoc_cache_lru_sim_top u_dut (.*);

  sacl_result_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side backpressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_req(logic [1:0] f, logic [47:0] a);
    in_valid <= 1'b1;
    func <= f;
    address <= a;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_SET_BITS:   cur_sb = (val[3:0] > MaxSetBits) ? MaxSetBits : val[3:0];
      CFG_BLOCK_BITS: cur_bb = val;
      CFG_WAYS:       cur_ways = (val[3:0] == 0) ? 1 : (val[3:0] > MaxWays) ? MaxWays : val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_cache(int sb, int bb, int ways);
    drain();
    write_reg(CFG_SET_BITS, 5'(sb));
    write_reg(CFG_BLOCK_BITS, 5'(bb));
    write_reg(CFG_WAYS, 5'(ways));
  endtask

  // mostly addresses that reuse a few tags in a few sets, so hits and LRU evictions happen
  function automatic logic [47:0] pick_addr();
    logic [47:0] tag, set, off;
    if ($urandom_range(0, 4) == 0) return {16'($urandom), $urandom};
    tag = 48'($urandom_range(0, cur_ways + 2));
    if ($urandom_range(0, 7) == 0) tag = tag | {16'($urandom), $urandom};
    set = 48'($urandom_range(0, 3)) & ((48'd1 << cur_sb) - 1);
    off = {16'($urandom), $urandom} & ((48'd1 << cur_bb) - 1);
    return (tag << (cur_sb + cur_bb)) | (set << cur_bb) | off;
  endfunction

  function automatic logic [1:0] pick_func();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return FUNC_INSTR;
    if (r < 4) return FUNC_LOAD;
    if (r < 7) return FUNC_STORE;
    return FUNC_MODIFY;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults are 4 set bits, 4 offset bits, direct mapped
    send_req(FUNC_INSTR, '1);
    send_req(FUNC_LOAD, 48'h0);
    send_req(FUNC_LOAD, 48'h0);
    send_req(FUNC_STORE, '1);
    send_req(FUNC_MODIFY, 48'h100);
    send_req(FUNC_LOAD, 48'h0);
    write_reg(CfgUnused, 5'h1f);
    // one set, 8 ways: fill, then evict by age
    set_cache(0, 0, 8);
    for (int i = 0; i < 9; i++) send_req(FUNC_LOAD, 48'(i));
    send_req(FUNC_MODIFY, 48'd2);
    send_req(FUNC_STORE, 48'd20);
    // duplicate tags after shrinking and growing the way count
    set_cache(0, 0, 2);
    send_req(FUNC_LOAD, 48'd40);
    send_req(FUNC_LOAD, 48'd41);
    write_reg(CFG_WAYS, 5'd1);
    send_req(FUNC_LOAD, 48'd41);
    write_reg(CFG_WAYS, 5'd2);
    send_req(FUNC_LOAD, 48'd41);
    // set bits above the limit, widest offset, ways 0 and over the limit
    set_cache(15, 31, 0);
    send_req(FUNC_LOAD, '1);
    send_req(FUNC_LOAD, 48'h7fff_ffff_ffff);
    write_reg(CFG_WAYS, 5'd15);
    send_req(FUNC_STORE, '1);

    drain(); // sender waits for all results once
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_cache(0, 0, 8);
        1: set_cache(10, 16, 8);
        2: set_cache(1, 0, 1);
        3: set_cache(10, 0, 15);
        4: set_cache(4, 31, 3);
        default: set_cache($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 15));
      endcase
      calm = (p == 9);
      repeat (200) send_req(pick_func(), pick_addr());
    end

    drain();
    $display("%0d requests, %0d register writes, %0d hits observed, %0d cycles",
             sent, cfg_writes, hits_seen, cycles);
    $display("covered fills, LRU evictions, modify, ignored fetches, config extremes");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/sacl_pkg.sv
rtl/sacl_front.sv
rtl/sacl_back.sv
rtl/set_assoc_cache_lru_sim_top.sv
rtl/sacl_checker.sv
tb/sacl_result_checker.sv
tb/tb_set_assoc_cache_lru_sim_top.sv
